FILE: design/dlc_pkg.sv
// Shared types, constants and the control program of the door lock controller.
package dlc_pkg;

  // Code geometry
  localparam int CODE_LENGTH = 5;
  localparam int POS_W = $clog2(CODE_LENGTH + 1);
  localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

  // Item actions
  localparam logic [1:0] ACT_BOOT = 2'd0;
  localparam logic [1:0] ACT_LINK = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  // Link bytes with a meaning
  localparam logic [7:0] LINK_CODE_FOUND = 8'd20;
  localparam logic [7:0] LINK_MENU_OPEN  = 8'd4;
  localparam logic [7:0] LINK_MENU_NEW   = 8'd5;

  // Status codes sent on the link
  localparam logic [3:0] ST_ERROR     = 4'd0;
  localparam logic [3:0] ST_CONFIRM   = 4'd1;
  localparam logic [3:0] ST_REPEATED  = 4'd2;
  localparam logic [3:0] ST_DONE      = 4'd7;
  localparam logic [3:0] ST_UNLOCKING = 4'd8;
  localparam logic [3:0] ST_LOCKING   = 4'd9;
  localparam logic [3:0] ST_STOP      = 4'd10;

  // Motor levels
  localparam logic [1:0] MOTOR_STOP   = 2'd0;
  localparam logic [1:0] MOTOR_UNLOCK = 2'd1;
  localparam logic [1:0] MOTOR_LOCK   = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_ATTEMPT_LIMIT    = 3'd0;
  localparam logic [2:0] CFG_TICKS_PER_SECOND = 3'd1;
  localparam logic [2:0] CFG_OPEN_SECONDS     = 3'd2;
  localparam logic [2:0] CFG_PAUSE_SECONDS    = 3'd3;
  localparam logic [2:0] CFG_ALARM_SECONDS    = 3'd4;

  localparam logic [6:0] SECOND_MAX = 7'd127;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
  } cmd_item_t;

  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_byte;
    logic [1:0] motor_drive;
    logic       buzzer_on;
    logic       store_write;
    logic [3:0] store_index;
    logic [7:0] store_data;
    logic       last;
  } res_item_t;

  // Controller mode
  typedef enum logic [10:0] {
    M_BOOT     = 11'h001,
    M_DECIDE   = 11'h002,
    M_ENTRY1   = 11'h004,
    M_ENTRY2   = 11'h008,
    M_MENU     = 11'h010,
    M_CHK_OPEN = 11'h020,
    M_CHK_NEW  = 11'h040,
    M_OPENING  = 11'h080,
    M_PAUSE    = 11'h100,
    M_LOCKING  = 11'h200,
    M_ALARM    = 11'h400
  } mode_t;

  // Datapath operations
  typedef enum logic [4:0] {
    OP_NONE, OP_BOOT, OP_DECIDE, OP_MENU, OP_ENTRY1, OP_CMP_FIRST, OP_CMP_STORED,
    OP_CONFIRM, OP_SAVE, OP_GO_MENU, OP_FAIL_INC, OP_RETRY, OP_ALARM, OP_CLR_FAIL,
    OP_START_ENTRY1, OP_OPEN, OP_TICK, OP_ENTER_PAUSE, OP_ENTER_LOCK, OP_DOOR_DONE
  } op_t;

  // Branch conditions
  typedef enum logic [3:0] {
    C_ALWAYS, C_POS_LT_LEN, C_MISMATCH, C_FAIL_GE_LIMIT, C_MODE_CHK_OPEN,
    C_POS_NE_LAST, C_MODE_ALARM, C_OPEN_DUE, C_PAUSE_DUE, C_LOCK_DUE, C_ALARM_DUE
  } cond_t;

  // Sequencing: next step, finish, branch else next, branch else finish
  typedef enum logic [1:0] {SQ_NEXT, SQ_END, SQ_BR, SQ_BR_END} seq_t;

  typedef enum logic [1:0] {EM_NONE, EM_STATUS, EM_ECHO, EM_STORE} emit_t;

  typedef enum logic [1:0] {LS_NO, LS_YES, LS_IFNOT} last_sel_t;

  localparam int UA_W = 6;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    seq_t            seq;
    logic [UA_W-1:0] target;
    emit_t           emit;
    logic [3:0]      status;
    last_sel_t       last_sel;
  } uword_t;

  // Control word for the datapath, valid when fire is high
  typedef struct packed {
    logic       fire;
    op_t        op;
    emit_t      emit;
    logic [3:0] status;
    logic       last;
  } ctrl_t;

  // Datapath state seen by the sequencer
  typedef struct packed {
    mode_t mode;
    logic  pos_lt_len;
    logic  mismatch;
    logic  fail_ge_limit;
    logic  pos_ne_last;
    logic  open_due;
    logic  pause_due;
    logic  lock_due;
    logic  alarm_due;
  } flags_t;

  // Program addresses
  localparam logic [UA_W-1:0] A_END        = 6'd0;
  localparam logic [UA_W-1:0] A_BOOT       = 6'd1;
  localparam logic [UA_W-1:0] A_DECIDE     = 6'd2;
  localparam logic [UA_W-1:0] A_MENU       = 6'd3;
  localparam logic [UA_W-1:0] A_ENTRY1     = 6'd4;
  localparam logic [UA_W-1:0] A_ENTRY2     = 6'd5;
  localparam logic [UA_W-1:0] A_E2_POS     = 6'd6;
  localparam logic [UA_W-1:0] A_E2_MIS     = 6'd7;
  localparam logic [UA_W-1:0] A_E2_CONF    = 6'd8;
  localparam logic [UA_W-1:0] A_SAVE       = 6'd9;
  localparam logic [UA_W-1:0] A_SAVE_END   = 6'd10;
  localparam logic [UA_W-1:0] A_CHK        = 6'd11;
  localparam logic [UA_W-1:0] A_CHK_POS    = 6'd12;
  localparam logic [UA_W-1:0] A_CHK_MIS    = 6'd13;
  localparam logic [UA_W-1:0] A_CHK_CONF   = 6'd14;
  localparam logic [UA_W-1:0] A_CHK_NEW    = 6'd15;
  localparam logic [UA_W-1:0] A_OPEN       = 6'd16;
  localparam logic [UA_W-1:0] A_OPEN_EMIT  = 6'd17;
  localparam logic [UA_W-1:0] A_FAIL       = 6'd18;
  localparam logic [UA_W-1:0] A_FAIL_TEST  = 6'd19;
  localparam logic [UA_W-1:0] A_FAIL_ERR   = 6'd20;
  localparam logic [UA_W-1:0] A_ALARM      = 6'd21;
  localparam logic [UA_W-1:0] A_ALARM_EMIT = 6'd22;
  localparam logic [UA_W-1:0] A_TICK       = 6'd23;
  localparam logic [UA_W-1:0] A_T_ALARM    = 6'd24;
  localparam logic [UA_W-1:0] A_T_OPEN     = 6'd25;
  localparam logic [UA_W-1:0] A_T_PAUSE    = 6'd26;
  localparam logic [UA_W-1:0] A_T_LOCK     = 6'd27;
  localparam logic [UA_W-1:0] A_TSTOP      = 6'd28;
  localparam logic [UA_W-1:0] A_TSTOP_EMIT = 6'd29;
  localparam logic [UA_W-1:0] A_TLOCK      = 6'd30;
  localparam logic [UA_W-1:0] A_TLOCK_EMIT = 6'd31;
  localparam logic [UA_W-1:0] A_TDONE      = 6'd32;
  localparam logic [UA_W-1:0] A_TDONE_EMIT = 6'd33;
  localparam logic [UA_W-1:0] A_TALARM     = 6'd34;
  localparam logic [UA_W-1:0] A_TALARM_END = 6'd35;

  function automatic uword_t mk_uw(op_t op, cond_t cond, seq_t seq,
                                   logic [UA_W-1:0] target, emit_t emit,
                                   logic [3:0] status, last_sel_t last_sel);
    uword_t w;
    w.op       = op;
    w.cond     = cond;
    w.seq      = seq;
    w.target   = target;
    w.emit     = emit;
    w.status   = status;
    w.last_sel = last_sel;
    return w;
  endfunction

  // Control program
  function automatic uword_t ucode_rom(logic [UA_W-1:0] addr);
    uword_t w;
    w = mk_uw(OP_NONE, C_ALWAYS, SQ_END, A_END, EM_NONE, ST_ERROR, LS_NO);
    case (addr)
      A_END:        w = mk_uw(OP_NONE, C_ALWAYS, SQ_END, A_END, EM_NONE, ST_ERROR, LS_NO);
      A_BOOT:       w = mk_uw(OP_BOOT, C_ALWAYS, SQ_END, A_END, EM_ECHO, ST_ERROR, LS_YES);
      A_DECIDE:     w = mk_uw(OP_DECIDE, C_ALWAYS, SQ_END, A_END, EM_NONE, ST_ERROR, LS_NO);
      A_MENU:       w = mk_uw(OP_MENU, C_ALWAYS, SQ_END, A_END, EM_NONE, ST_ERROR, LS_NO);
      A_ENTRY1:     w = mk_uw(OP_ENTRY1, C_ALWAYS, SQ_END, A_END, EM_NONE, ST_ERROR, LS_NO);
      A_ENTRY2:     w = mk_uw(OP_CMP_FIRST, C_ALWAYS, SQ_NEXT, A_END, EM_NONE, ST_ERROR,
                              LS_NO);
      A_E2_POS:     w = mk_uw(OP_NONE, C_POS_LT_LEN, SQ_BR, A_END, EM_NONE, ST_ERROR, LS_NO);
      A_E2_MIS:     w = mk_uw(OP_NONE, C_MISMATCH, SQ_BR, A_FAIL, EM_NONE, ST_ERROR, LS_NO);
      A_E2_CONF:    w = mk_uw(OP_CONFIRM, C_ALWAYS, SQ_NEXT, A_END, EM_STATUS, ST_CONFIRM,
                              LS_NO);
      A_SAVE:       w = mk_uw(OP_SAVE, C_POS_NE_LAST, SQ_BR, A_SAVE, EM_STORE, ST_ERROR,
                              LS_IFNOT);
      A_SAVE_END:   w = mk_uw(OP_GO_MENU, C_ALWAYS, SQ_END, A_END, EM_NONE, ST_ERROR, LS_NO);
      A_CHK:        w = mk_uw(OP_CMP_STORED, C_ALWAYS, SQ_NEXT, A_END, EM_NONE, ST_ERROR,
                              LS_NO);
      A_CHK_POS:    w = mk_uw(OP_NONE, C_POS_LT_LEN, SQ_BR, A_END, EM_NONE, ST_ERROR, LS_NO);
      A_CHK_MIS:    w = mk_uw(OP_NONE, C_MISMATCH, SQ_BR, A_FAIL, EM_NONE, ST_ERROR, LS_NO);
      A_CHK_CONF:   w = mk_uw(OP_CLR_FAIL, C_MODE_CHK_OPEN, SQ_BR, A_OPEN, EM_STATUS,
                              ST_CONFIRM, LS_IFNOT);
      A_CHK_NEW:    w = mk_uw(OP_START_ENTRY1, C_ALWAYS, SQ_END, A_END, EM_NONE, ST_ERROR,
                              LS_NO);
      A_OPEN:       w = mk_uw(OP_OPEN, C_ALWAYS, SQ_NEXT, A_END, EM_NONE, ST_ERROR, LS_NO);
      A_OPEN_EMIT:  w = mk_uw(OP_NONE, C_ALWAYS, SQ_END, A_END, EM_STATUS, ST_UNLOCKING,
                              LS_YES);
      A_FAIL:       w = mk_uw(OP_FAIL_INC, C_ALWAYS, SQ_NEXT, A_END, EM_NONE, ST_ERROR, LS_NO);
      A_FAIL_TEST:  w = mk_uw(OP_NONE, C_FAIL_GE_LIMIT, SQ_BR, A_ALARM, EM_NONE, ST_ERROR,
                              LS_NO);
      A_FAIL_ERR:   w = mk_uw(OP_RETRY, C_ALWAYS, SQ_END, A_END, EM_STATUS, ST_ERROR, LS_YES);
      A_ALARM:      w = mk_uw(OP_ALARM, C_ALWAYS, SQ_NEXT, A_END, EM_NONE, ST_ERROR, LS_NO);
      A_ALARM_EMIT: w = mk_uw(OP_NONE, C_ALWAYS, SQ_END, A_END, EM_STATUS, ST_REPEATED,
                              LS_YES);
      A_TICK:       w = mk_uw(OP_TICK, C_ALWAYS, SQ_NEXT, A_END, EM_NONE, ST_ERROR, LS_NO);
      A_T_ALARM:    w = mk_uw(OP_NONE, C_MODE_ALARM, SQ_BR, A_TALARM, EM_NONE, ST_ERROR,
                              LS_NO);
      A_T_OPEN:     w = mk_uw(OP_NONE, C_OPEN_DUE, SQ_BR, A_TSTOP, EM_NONE, ST_ERROR, LS_NO);
      A_T_PAUSE:    w = mk_uw(OP_NONE, C_PAUSE_DUE, SQ_BR, A_TLOCK, EM_NONE, ST_ERROR, LS_NO);
      A_T_LOCK:     w = mk_uw(OP_NONE, C_LOCK_DUE, SQ_BR_END, A_TDONE, EM_NONE, ST_ERROR,
                              LS_NO);
      A_TSTOP:      w = mk_uw(OP_ENTER_PAUSE, C_ALWAYS, SQ_NEXT, A_END, EM_NONE, ST_ERROR,
                              LS_NO);
      A_TSTOP_EMIT: w = mk_uw(OP_NONE, C_PAUSE_DUE, SQ_BR_END, A_TLOCK, EM_STATUS, ST_STOP,
                              LS_IFNOT);
      A_TLOCK:      w = mk_uw(OP_ENTER_LOCK, C_ALWAYS, SQ_NEXT, A_END, EM_NONE, ST_ERROR,
                              LS_NO);
      A_TLOCK_EMIT: w = mk_uw(OP_NONE, C_LOCK_DUE, SQ_BR_END, A_TDONE, EM_STATUS, ST_LOCKING,
                              LS_IFNOT);
      A_TDONE:      w = mk_uw(OP_DOOR_DONE, C_ALWAYS, SQ_NEXT, A_END, EM_NONE, ST_ERROR,
                              LS_NO);
      A_TDONE_EMIT: w = mk_uw(OP_NONE, C_ALWAYS, SQ_END, A_END, EM_STATUS, ST_DONE, LS_YES);
      A_TALARM:     w = mk_uw(OP_NONE, C_ALARM_DUE, SQ_BR_END, A_TALARM_END, EM_NONE,
                              ST_ERROR, LS_NO);
      A_TALARM_END: w = mk_uw(OP_GO_MENU, C_ALWAYS, SQ_BR, A_TDONE_EMIT, EM_NONE, ST_ERROR,
                              LS_NO);
      default:      w = mk_uw(OP_NONE, C_ALWAYS, SQ_END, A_END, EM_NONE, ST_ERROR, LS_NO);
    endcase
    return w;
  endfunction

endpackage

FILE: design/passcode_door_lock_controller.sv
// Passcode door lock controller: top level with item handshake and result register.
// An item runs through a short control program, one control word per cycle unless an
// emitting step waits on res_stall; the block stays busy from acceptance to the program's end.
// A result is registered and appears in the result register in the cycle after the step that makes it.
// Reset (rst, synchronous, active high) returns to boot loading with default registers.
module passcode_door_lock_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  dlc_pkg::cmd_item_t  cmd,
  output logic                res_valid,
  input  logic                res_stall,
  output dlc_pkg::res_item_t  res,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [7:0]          cfg_data
);
  import dlc_pkg::*;

  logic      cmd_accept;
  logic      busy;
  logic      hold;
  logic      emit_fire;
  ctrl_t     ctrl;
  flags_t    flags;
  res_item_t result;

  // Take a new item only when the program has finished the previous one
  assign cmd_stall  = busy;
  assign cmd_accept = cmd_valid && !cmd_stall;

  // The result register is full and the far side is not taking it
  assign hold = res_valid && res_stall;

  // An emitting step fires only when the result register can take its item
  assign emit_fire = ctrl.fire && (ctrl.emit != EM_NONE);

  dlc_sequencer u_seq (
    .clk        (clk),
    .rst        (rst),
    .cmd_accept (cmd_accept),
    .cmd_action (cmd.action),
    .hold       (hold),
    .flags      (flags),
    .busy       (busy),
    .ctrl       (ctrl)
  );

  dlc_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd_accept (cmd_accept),
    .cmd_byte   (cmd.data_byte),
    .ctrl       (ctrl),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .flags      (flags),
    .result     (result)
  );

  // Result register: load on an emitting step, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit_fire) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) res <= result;
  end

`ifndef SYNTHESIS
  // An accepted item starts the program, so the block is busy after it
  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    cmd_accept |=> cmd_stall)
    else $error("item accepted without starting the program");

  // No result is loaded over one that still waits to be taken
  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    hold |-> !emit_fire)
    else $error("result register overwritten while stalled");

  // Motor and buzzer never run together
  a_motor_buzzer : assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.buzzer_on && (res.motor_drive != MOTOR_STOP)))
    else $error("motor driven during alarm");

  // Store writes stay inside the code
  a_store_index : assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.store_write) |-> (32'(res.store_index) < CODE_LENGTH))
    else $error("store index beyond code length");
`endif

endmodule

FILE: design/dlc_sequencer.sv
// Step counter, program table lookup and branch logic of the door lock controller.
module dlc_sequencer (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_accept,
  input  logic [1:0]        cmd_action,
  input  logic              hold,
  input  dlc_pkg::flags_t   flags,
  output logic              busy,
  output dlc_pkg::ctrl_t    ctrl
);
  import dlc_pkg::*;

  typedef enum logic [1:0] {
    SEQ_IDLE = 2'b01,
    SEQ_RUN  = 2'b10
  } seq_state_t;

  seq_state_t      state;
  logic [UA_W-1:0] pc;
  uword_t          uw;
  logic            cond_true;
  logic            step_ok;

  // Entry point of the program for an item
  function automatic logic [UA_W-1:0] dispatch(logic [1:0] action, mode_t m);
    logic [UA_W-1:0] a;
    a = A_END;
    case (action)
      ACT_BOOT: a = (m == M_BOOT) ? A_BOOT : A_END;
      ACT_LINK: begin
        unique case (m) inside
          M_DECIDE:              a = A_DECIDE;
          M_MENU:                a = A_MENU;
          M_ENTRY1:              a = A_ENTRY1;
          M_ENTRY2:              a = A_ENTRY2;
          M_CHK_OPEN, M_CHK_NEW: a = A_CHK;
          default:               a = A_END;
        endcase
      end
      ACT_TICK: begin
        unique case (m) inside
          M_ALARM, M_OPENING, M_PAUSE, M_LOCKING: a = A_TICK;
          default:                                a = A_END;
        endcase
      end
      default: a = A_END;
    endcase
    return a;
  endfunction

  assign uw = ucode_rom(pc);

  always_comb begin
    unique case (uw.cond)
      C_ALWAYS:        cond_true = 1'b1;
      C_POS_LT_LEN:    cond_true = flags.pos_lt_len;
      C_MISMATCH:      cond_true = flags.mismatch;
      C_FAIL_GE_LIMIT: cond_true = flags.fail_ge_limit;
      C_MODE_CHK_OPEN: cond_true = (flags.mode == M_CHK_OPEN);
      C_POS_NE_LAST:   cond_true = flags.pos_ne_last;
      C_MODE_ALARM:    cond_true = (flags.mode == M_ALARM);
      C_OPEN_DUE:      cond_true = flags.open_due;
      C_PAUSE_DUE:     cond_true = flags.pause_due;
      C_LOCK_DUE:      cond_true = flags.lock_due;
      C_ALARM_DUE:     cond_true = flags.alarm_due;
      default:         cond_true = 1'b0;
    endcase
  end

  // Hold a step that emits while the result register is full and stalled
  assign step_ok = (state == SEQ_RUN) && !((uw.emit != EM_NONE) && hold);
  assign busy    = (state == SEQ_RUN);

  always_comb begin
    ctrl.fire   = step_ok;
    ctrl.op     = uw.op;
    ctrl.emit   = uw.emit;
    ctrl.status = uw.status;
    unique case (uw.last_sel)
      LS_NO:    ctrl.last = 1'b0;
      LS_YES:   ctrl.last = 1'b1;
      LS_IFNOT: ctrl.last = !cond_true;
      default:  ctrl.last = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
      pc    <= A_END;
    end else begin
      unique case (state)
        SEQ_IDLE: begin
          if (cmd_accept) begin
            pc    <= dispatch(cmd_action, flags.mode);
            state <= SEQ_RUN;
          end
        end
        SEQ_RUN: begin
          if (step_ok) begin
            unique case (uw.seq)
              SQ_NEXT: pc <= pc + UA_W'(1);
              SQ_END:  state <= SEQ_IDLE;
              SQ_BR:   pc <= cond_true ? uw.target : pc + UA_W'(1);
              SQ_BR_END: begin
                if (cond_true) begin
                  pc <= uw.target;
                end else begin
                  state <= SEQ_IDLE;
                end
              end
              default: state <= SEQ_IDLE;
            endcase
          end
        end
        default: state <= SEQ_IDLE;
      endcase
    end
  end

endmodule

FILE: design/dlc_datapath.sv
// Code stores, counters, configuration registers and result forming of the door lock controller.
module dlc_datapath (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_accept,
  input  logic [7:0]         cmd_byte,
  input  dlc_pkg::ctrl_t     ctrl,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  output dlc_pkg::flags_t    flags,
  output dlc_pkg::res_item_t result
);
  import dlc_pkg::*;

  logic [3:0]       attempt_limit;
  logic [7:0]       ticks_per_second;
  logic [5:0]       open_seconds;
  logic [5:0]       pause_seconds;
  logic [5:0]       alarm_seconds;

  mode_t            mode;
  logic [POS_W-1:0] byte_position;
  logic             mismatch_seen;
  logic [3:0]       fail_count;
  logic [7:0]       tick_count;
  logic [6:0]       second_count;
  logic [7:0]       data_byte;
  logic [7:0]       stored_code [CODE_LENGTH];
  logic [7:0]       first_entry [CODE_LENGTH];

  logic [IDX_W-1:0] idx;
  logic [POS_W-1:0] pos_inc;
  logic             pos_wrap;
  logic [7:0]       tick_inc;
  logic             pos_lt_len;

  assign idx        = byte_position[IDX_W-1:0];
  assign pos_inc    = byte_position + POS_W'(1);
  assign pos_wrap   = (pos_inc >= POS_W'(CODE_LENGTH));
  assign tick_inc   = tick_count + 8'd1;
  assign pos_lt_len = (byte_position < POS_W'(CODE_LENGTH));

  always_comb begin
    flags.mode          = mode;
    flags.pos_lt_len    = pos_lt_len;
    flags.mismatch      = mismatch_seen;
    flags.fail_ge_limit = (fail_count >= attempt_limit);
    flags.pos_ne_last   = (byte_position != POS_W'(CODE_LENGTH - 1));
    flags.open_due      = (mode == M_OPENING) && (second_count >= 7'(open_seconds));
    flags.pause_due     = (mode == M_PAUSE) && (second_count >= 7'(pause_seconds));
    flags.lock_due      = (mode == M_LOCKING) && (second_count >= 7'(open_seconds));
    flags.alarm_due     = (second_count >= 7'(alarm_seconds));
  end

  // Result fields; motor and buzzer follow the mode as it stands
  always_comb begin
    result.send_valid  = (ctrl.emit == EM_STATUS) || (ctrl.emit == EM_ECHO);
    result.send_byte   = (ctrl.emit == EM_STATUS) ? {4'd0, ctrl.status} :
                         (ctrl.emit == EM_ECHO)   ? data_byte : 8'd0;
    result.motor_drive = (mode == M_OPENING) ? MOTOR_UNLOCK :
                         (mode == M_LOCKING) ? MOTOR_LOCK : MOTOR_STOP;
    result.buzzer_on   = (mode == M_ALARM);
    result.store_write = (ctrl.emit == EM_STORE);
    result.store_index = (ctrl.emit == EM_STORE) ? 4'(idx) : 4'd0;
    result.store_data  = (ctrl.emit == EM_STORE) ? first_entry[idx] : 8'd0;
    result.last        = ctrl.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      attempt_limit    <= 4'd3;
      ticks_per_second <= 8'd31;
      open_seconds     <= 6'd15;
      pause_seconds    <= 6'd3;
      alarm_seconds    <= 6'd60;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ATTEMPT_LIMIT:    attempt_limit    <= cfg_data[3:0];
        CFG_TICKS_PER_SECOND: ticks_per_second <= cfg_data;
        CFG_OPEN_SECONDS:     open_seconds     <= cfg_data[5:0];
        CFG_PAUSE_SECONDS:    pause_seconds    <= cfg_data[5:0];
        CFG_ALARM_SECONDS:    alarm_seconds    <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= M_BOOT;
      byte_position <= '0;
      mismatch_seen <= 1'b0;
      fail_count    <= 4'd0;
      tick_count    <= 8'd0;
      second_count  <= 7'd0;
    end else if (ctrl.fire) begin
      unique case (ctrl.op)
        OP_NONE: ;
        OP_BOOT: begin
          if (pos_wrap) begin
            byte_position <= '0;
            mode          <= M_DECIDE;
          end else begin
            byte_position <= pos_inc;
          end
        end
        OP_DECIDE: begin
          if (data_byte == LINK_CODE_FOUND) begin
            mode <= M_MENU;
          end else begin
            mode          <= M_ENTRY1;
            byte_position <= '0;
            mismatch_seen <= 1'b0;
          end
        end
        OP_MENU: begin
          mode          <= (data_byte == LINK_MENU_OPEN) ? M_CHK_OPEN :
                           (data_byte == LINK_MENU_NEW)  ? M_CHK_NEW : M_ENTRY1;
          byte_position <= '0;
          mismatch_seen <= 1'b0;
        end
        OP_ENTRY1: begin
          if (pos_wrap) begin
            mode          <= M_ENTRY2;
            byte_position <= '0;
            mismatch_seen <= 1'b0;
          end else begin
            byte_position <= pos_inc;
          end
        end
        OP_CMP_FIRST: begin
          if (pos_lt_len && (first_entry[idx] != data_byte)) mismatch_seen <= 1'b1;
          byte_position <= pos_inc;
        end
        OP_CMP_STORED: begin
          if (pos_lt_len && (stored_code[idx] != data_byte)) mismatch_seen <= 1'b1;
          byte_position <= pos_inc;
        end
        OP_CONFIRM: begin
          fail_count    <= 4'd0;
          byte_position <= '0;
        end
        OP_SAVE:     byte_position <= pos_inc;
        OP_GO_MENU:  mode <= M_MENU;
        OP_FAIL_INC: fail_count <= fail_count + 4'd1;
        OP_RETRY: begin
          if (mode == M_ENTRY2) mode <= M_ENTRY1;
          byte_position <= '0;
          mismatch_seen <= 1'b0;
        end
        OP_ALARM: begin
          fail_count   <= 4'd0;
          mode         <= M_ALARM;
          tick_count   <= 8'd0;
          second_count <= 7'd0;
        end
        OP_CLR_FAIL: fail_count <= 4'd0;
        OP_START_ENTRY1: begin
          mode          <= M_ENTRY1;
          byte_position <= '0;
          mismatch_seen <= 1'b0;
        end
        OP_OPEN: begin
          tick_count   <= 8'd0;
          mode         <= M_OPENING;
          second_count <= 7'd0;
        end
        OP_TICK: begin
          if (tick_inc >= ticks_per_second) begin
            tick_count <= 8'd0;
            if (second_count < SECOND_MAX) second_count <= second_count + 7'd1;
          end else begin
            tick_count <= tick_inc;
          end
        end
        OP_ENTER_PAUSE: begin
          mode         <= M_PAUSE;
          second_count <= 7'd0;
        end
        OP_ENTER_LOCK: begin
          mode         <= M_LOCKING;
          second_count <= 7'd0;
        end
        OP_DOOR_DONE: begin
          mode         <= M_MENU;
          tick_count   <= 8'd0;
          second_count <= 7'd0;
        end
        default: ;
      endcase
    end
  end

  // Item byte and code stores carry no reset
  always_ff @(posedge clk) begin
    if (cmd_accept) data_byte <= cmd_byte;
    if (ctrl.fire) begin
      case (ctrl.op)
        OP_BOOT:   if (pos_lt_len) stored_code[idx] <= data_byte;
        OP_ENTRY1: if (pos_lt_len) first_entry[idx] <= data_byte;
        OP_SAVE:   stored_code[idx] <= first_entry[idx];
        default: ;
      endcase
    end
  end

endmodule
